>>> design/ppt_pkg.sv
// Package for the pointer position tracker: register indexes, cursor
// extents, screen size limits and the size saturation and clamp functions.
// No dependencies.
package ppt_pkg;

    // Register indexes on the configuration port (byte address = 4 * index).
    typedef enum logic {
        REG_SCREEN_WIDTH  = 1'b0,
        REG_SCREEN_HEIGHT = 1'b1
    } t_reg_idx;

    localparam logic [12:0] SCREEN_MIN    = 13'd32;
    localparam logic [12:0] SCREEN_MAX    = 13'd4096;
    localparam logic [12:0] WIDTH_RESET   = 13'd1024;
    localparam logic [12:0] HEIGHT_RESET  = 13'd768;
    localparam logic [11:0] CUR_X_RESET   = 12'd512;
    localparam logic [11:0] CUR_Y_RESET   = 12'd384;

    // Cursor bitmap extents in pixels.
    localparam logic [4:0]  CURSOR_W      = 5'd15;
    localparam logic [4:0]  CURSOR_H      = 5'd19;

    // Fields of one accepted report that stages A to D carry along.
    typedef struct packed {
        logic               is_absolute;
        logic signed [15:0] move_x;
        logic signed [15:0] move_y;
        logic [2:0]         buttons;
    } t_ctl;

    // Register values outside the legal range are used as the nearest limit.
    function automatic logic [12:0] sat_size(input logic [12:0] v);
        logic [12:0] r;
        r = v;
        if (v < SCREEN_MIN) r = SCREEN_MIN;
        if (v > SCREEN_MAX) r = SCREEN_MAX;
        return r;
    endfunction

    // Clamp to at least zero, then pull back so the cursor stays on screen.
    function automatic logic [11:0] clamp_pos(input logic signed [17:0] p,
                                              input logic [12:0]        size,
                                              input logic [4:0]         extent);
        logic [16:0] p0;
        logic [17:0] reach;
        logic [12:0] limit;
        p0    = p[17] ? 17'd0 : p[16:0];
        reach = {1'b0, p0} + {13'd0, extent};
        limit = size - {8'd0, extent};
        if (reach > {5'd0, size}) return limit[11:0];
        return p0[11:0];
    endfunction

endpackage

>>> design/pointer_position_tracker.sv
// Pointer position tracker: scales absolute reports, integrates relative
// motion and keeps a 15x19 cursor on a screen of configured size.
// Depends on ppt_pkg.
//
//  Channel   Direction  Transfer condition             Contents
//  s_axis    in         s_axis_tvalid & s_axis_tready  one mouse report
//  m_axis    out        m_axis_tvalid & m_axis_tready  clamped position, changed
//  APB       in         psel & penable & pwrite        screen width / height
//
// A report reaches the result register through input register, tablet product,
// reciprocal estimate, quotient correction and clamp with cursor state update;
// one report per cycle is sustained while m_axis_tready stays high.
// Reset (synchronous, active low) empties the pipeline, restores the screen size
// registers and centers the cursor. While a result waits, the input keeps taking
// reports until all five stages are full, and then it stalls.
module pointer_position_tracker
    import ppt_pkg::*;
#(
    parameter int ABS_MAX = 32767
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Reports in.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] raw_x, [31:16] raw_y, [47:32] move_x, [63:48] move_y,
    // [66:64] buttons, [71:67] zero
    input  logic [71:0] s_axis_tdata,
    // [0] is_absolute
    input  logic [0:0]  s_axis_tuser,

    // Results out.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [11:0] pointer_x, [23:12] pointer_y
    output logic [23:0] m_axis_tdata,
    // [0] changed
    output logic [0:0]  m_axis_tuser,

    // Configuration.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Tablet scaling computes floor(r * (size - 1) / ABS_MAX). The product is
    // below 2**P_W, so the reciprocal K = floor(2**P_W / ABS_MAX) gives an
    // estimate that is either exact or one short; a single compare fixes it.
    localparam int P_W   = $clog2(ABS_MAX * 4095 + 1);
    localparam int K_VAL = (2 ** P_W) / ABS_MAX;
    localparam int K_W   = $clog2(K_VAL + 1);
    localparam int PK_W  = P_W + K_W;

    localparam logic [15:0]   ABS_MAX_V = 16'(ABS_MAX);
    localparam logic [P_W-1:0] ABS_MAX_P = P_W'(ABS_MAX);
    localparam logic [PK_W-1:0] K_V      = PK_W'(K_VAL);

    // ------------------------------------------------------------------
    // Configuration registers. The block decodes only the register select
    // bit of the address; the byte offset bits are ignored.
    // ------------------------------------------------------------------
    logic [12:0] r_screen_width;
    logic [12:0] r_screen_height;
    logic        cfg_write;
    t_reg_idx    cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_idx   = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= WIDTH_RESET;
            r_screen_height <= HEIGHT_RESET;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                REG_SCREEN_WIDTH:  r_screen_width  <= pwdata[12:0];
                REG_SCREEN_HEIGHT: r_screen_height <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_SCREEN_WIDTH:  prdata = {19'd0, r_screen_width};
            REG_SCREEN_HEIGHT: prdata = {19'd0, r_screen_height};
            default:           prdata = 32'd0;
        endcase
    end

    // Effective screen size. Configuration only changes while the block is
    // idle, a rule on the user that the block itself does not enforce, so every stage uses the live registers.
    logic [12:0] size_w;
    logic [12:0] size_h;
    logic [11:0] size_w_m1;
    logic [11:0] size_h_m1;
    logic [12:0] size_w_dec;
    logic [12:0] size_h_dec;

    assign size_w     = sat_size(r_screen_width);
    assign size_h     = sat_size(r_screen_height);
    assign size_w_dec = size_w - 13'd1;
    assign size_h_dec = size_h - 13'd1;
    assign size_w_m1  = size_w_dec[11:0];
    assign size_h_m1  = size_h_dec[11:0];

    // ------------------------------------------------------------------
    // Pipeline valid bits and the ready chain. A stage takes a new item when
    // it is empty or its current item moves on in the same cycle.
    // ------------------------------------------------------------------
    logic r_a_v, r_b_v, r_c_v, r_d_v, r_e_v;
    logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;

    assign rdy_e = !r_e_v || m_axis_tready;
    assign rdy_d = !r_d_v || rdy_e;
    assign rdy_c = !r_c_v || rdy_d;
    assign rdy_b = !r_b_v || rdy_c;
    assign rdy_a = !r_a_v || rdy_b;

    assign s_axis_tready = rdy_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
        end else begin
            if (rdy_a) r_a_v <= s_axis_tvalid;
            if (rdy_b) r_b_v <= r_a_v;
            if (rdy_c) r_c_v <= r_b_v;
            if (rdy_d) r_d_v <= r_c_v;
            if (rdy_e) r_e_v <= r_d_v;
        end
    end

    // ------------------------------------------------------------------
    // Stage A: input register.
    // ------------------------------------------------------------------
    t_ctl        r_a_ctl;
    logic [15:0] r_a_raw_x;
    logic [15:0] r_a_raw_y;

    always_ff @(posedge i_clk) begin
        if (rdy_a) begin
            r_a_raw_x           <= s_axis_tdata[15:0];
            r_a_raw_y           <= s_axis_tdata[31:16];
            r_a_ctl.move_x      <= s_axis_tdata[47:32];
            r_a_ctl.move_y      <= s_axis_tdata[63:48];
            r_a_ctl.buttons     <= s_axis_tdata[66:64];
            r_a_ctl.is_absolute <= s_axis_tuser[0];
        end
    end

    // ------------------------------------------------------------------
    // Stage B: saturate the tablet coordinates and multiply by size - 1.
    // ------------------------------------------------------------------
    logic [15:0]    sat_x;
    logic [15:0]    sat_y;
    logic [P_W-1:0] n_b_prod_x;
    logic [P_W-1:0] n_b_prod_y;
    t_ctl           r_b_ctl;
    logic [P_W-1:0] r_b_prod_x;
    logic [P_W-1:0] r_b_prod_y;

    assign sat_x      = (r_a_raw_x > ABS_MAX_V) ? ABS_MAX_V : r_a_raw_x;
    assign sat_y      = (r_a_raw_y > ABS_MAX_V) ? ABS_MAX_V : r_a_raw_y;
    assign n_b_prod_x = P_W'(28'(sat_x) * 28'(size_w_m1));
    assign n_b_prod_y = P_W'(28'(sat_y) * 28'(size_h_m1));

    always_ff @(posedge i_clk) begin
        if (rdy_b) begin
            r_b_ctl    <= r_a_ctl;
            r_b_prod_x <= n_b_prod_x;
            r_b_prod_y <= n_b_prod_y;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: quotient estimate by the reciprocal of ABS_MAX.
    // ------------------------------------------------------------------
    logic [PK_W-1:0] recip_x;
    logic [PK_W-1:0] recip_y;
    t_ctl            r_c_ctl;
    logic [P_W-1:0]  r_c_prod_x;
    logic [P_W-1:0]  r_c_prod_y;
    logic [11:0]     r_c_est_x;
    logic [11:0]     r_c_est_y;

    assign recip_x = PK_W'(r_b_prod_x) * K_V;
    assign recip_y = PK_W'(r_b_prod_y) * K_V;

    always_ff @(posedge i_clk) begin
        if (rdy_c) begin
            r_c_ctl    <= r_b_ctl;
            r_c_prod_x <= r_b_prod_x;
            r_c_prod_y <= r_b_prod_y;
            r_c_est_x  <= recip_x[P_W +: 12];
            r_c_est_y  <= recip_y[P_W +: 12];
        end
    end

    // ------------------------------------------------------------------
    // Stage D: the estimate is at most one short; add one when the
    // remainder still reaches ABS_MAX.
    // ------------------------------------------------------------------
    logic [P_W-1:0] rem_x;
    logic [P_W-1:0] rem_y;
    t_ctl           r_d_ctl;
    logic [11:0]    r_d_q_x;
    logic [11:0]    r_d_q_y;

    assign rem_x = r_c_prod_x - P_W'(P_W'(r_c_est_x) * ABS_MAX_P);
    assign rem_y = r_c_prod_y - P_W'(P_W'(r_c_est_y) * ABS_MAX_P);

    always_ff @(posedge i_clk) begin
        if (rdy_d) begin
            r_d_ctl <= r_c_ctl;
            r_d_q_x <= r_c_est_x + 12'(rem_x >= ABS_MAX_P);
            r_d_q_y <= r_c_est_y + 12'(rem_y >= ABS_MAX_P);
        end
    end

    // ------------------------------------------------------------------
    // Stage E: pick the absolute or relative position, clamp it, update the
    // cursor state and load the result register. Vertical motion is
    // subtracted because positive move_y points up.
    // ------------------------------------------------------------------
    logic [11:0]        r_cur_x;
    logic [11:0]        r_cur_y;
    logic [2:0]         r_last_buttons;
    logic signed [17:0] pos_x;
    logic signed [17:0] pos_y;
    logic [11:0]        n_cur_x;
    logic [11:0]        n_cur_y;
    logic               n_changed;
    logic               take_d;
    logic [11:0]        r_out_x;
    logic [11:0]        r_out_y;
    logic               r_out_changed;

    assign take_d = r_d_v && rdy_e;

    always_comb begin
        if (r_d_ctl.is_absolute) begin
            pos_x     = $signed({6'd0, r_d_q_x});
            pos_y     = $signed({6'd0, r_d_q_y});
            n_changed = 1'b1;
        end else begin
            pos_x     = $signed({6'd0, r_cur_x}) + 18'(r_d_ctl.move_x);
            pos_y     = $signed({6'd0, r_cur_y}) - 18'(r_d_ctl.move_y);
            n_changed = (r_d_ctl.move_x != 16'sd0) || (r_d_ctl.move_y != 16'sd0)
                        || (r_d_ctl.buttons != r_last_buttons);
        end
        n_cur_x = clamp_pos(pos_x, size_w, CURSOR_W);
        n_cur_y = clamp_pos(pos_y, size_h, CURSOR_H);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x        <= CUR_X_RESET;
            r_cur_y        <= CUR_Y_RESET;
            r_last_buttons <= 3'd0;
        end else if (take_d) begin
            r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y;
            if (n_changed) r_last_buttons <= r_d_ctl.buttons;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_d) begin
            r_out_x       <= n_cur_x;
            r_out_y       <= n_cur_y;
            r_out_changed <= n_changed;
        end
    end

    assign m_axis_tvalid   = r_e_v;
    assign m_axis_tdata    = {r_out_y, r_out_x};
    assign m_axis_tuser[0] = r_out_changed;

endmodule
